### sv/sfwt_pkg.sv
package sfwt_pkg;

  // Port widths fixed by the interface
  localparam int OPCODE_W     = 3;
  localparam int VALUE_PORT_W = 64;
  localparam int POS_W        = 8;
  localparam int OCC_W        = 9;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ      = 3'd0,
    OP_DEQ      = 3'd1,
    OP_SEARCH   = 3'd2,
    OP_RM_FIRST = 3'd3,
    OP_RM_ALL   = 3'd4,
    OP_PEEK     = 3'd5,
    OP_POP      = 3'd6
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

### sv/sfwt_ctrl.sv
module sfwt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfwt_pkg::sts_t sts,
  output sfwt_pkg::cmd_t cmd
);
  import sfwt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one operation: take the beat, set up, scan, hand off the result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/sfwt_dp.sv
module sfwt_dp #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sfwt_pkg::cmd_t                      cmd,
  output sfwt_pkg::sts_t                      sts,
  input  logic [sfwt_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [sfwt_pkg::VALUE_PORT_W-1:0]   in_item_value,
  input  logic [sfwt_pkg::POS_W-1:0]          in_peek_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfwt_pkg::VALUE_PORT_W-1:0]   out_result_value,
  output logic                                out_hit,
  output logic                                out_entry_dead,
  output logic                                out_overflow,
  output logic [sfwt_pkg::OCC_W-1:0]          out_occupancy
);
  import sfwt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + POS_W + 1;
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Entry memories
  logic [VALUE_WIDTH-1:0] store_mem [DEPTH];
  logic                   live_mem  [DEPTH];

  // Operation registers
  op_t                    op_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [POS_W-1:0]       pos_r;

  // Queue pointers
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Scan pipeline
  logic [AW-1:0]          iss_addr_r, iss_addr_nxt;
  logic [CW-1:0]          iss_left_r, iss_left_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]          rd_addr_r;
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   rd_live_r;
  logic                   stop_r, stop_nxt;
  logic                   issue;

  // Result accumulators
  logic [VALUE_WIDTH-1:0] rv_r, rv_nxt;
  logic                   hit_r, hit_nxt;
  logic                   dead_r, dead_nxt;
  logic                   ovf_r, ovf_nxt;

  // Memory write controls
  logic          store_we;
  logic          live_we;
  logic [AW-1:0] live_waddr;
  logic          live_wdata;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_PORT_W-1:0] out_value_r;
  logic                    out_hit_r;
  logic                    out_dead_r;
  logic                    out_ovf_r;
  logic [OCC_W-1:0]        out_occ_r;

  // Peek address arithmetic
  logic [SW-1:0] slot_sum;
  logic [SW-1:0] slot_wrap;
  logic [AW-1:0] peek_slot;
  logic          peek_in_range;
  logic          match;

  logic [VALUE_PORT_W+VALUE_WIDTH-1:0] rv_ext;
  logic [OCC_W+CW-1:0]                 occ_ext;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] a);
    return (a == LAST_A) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ret(input logic [AW-1:0] a);
    return (a == '0) ? LAST_A : a - AW'(1);
  endfunction

  // Locate the peeked slot: head plus position, wrapped once
  always_comb begin
    slot_sum      = SW'(head_r) + SW'(pos_r);
    slot_wrap     = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
    peek_slot     = slot_wrap[AW-1:0];
    peek_in_range = SW'(pos_r) < SW'(count_r);
    match         = rd_live_r && (rd_data_r == val_r);
  end

  // Set up, issue reads and evaluate returned entries
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    iss_addr_nxt = iss_addr_r;
    iss_left_nxt = iss_left_r;
    rd_vld_nxt   = rd_vld_r;
    stop_nxt     = stop_r;
    rv_nxt       = rv_r;
    hit_nxt      = hit_r;
    dead_nxt     = dead_r;
    ovf_nxt      = ovf_r;
    store_we     = 1'b0;
    live_we      = 1'b0;
    live_waddr   = tail_r;
    live_wdata   = 1'b1;
    issue        = 1'b0;

    if (cmd.setup) begin
      stop_nxt     = 1'b0;
      rv_nxt       = '0;
      hit_nxt      = 1'b0;
      dead_nxt     = 1'b0;
      ovf_nxt      = 1'b0;
      rd_vld_nxt   = 1'b0;
      iss_addr_nxt = head_r;
      iss_left_nxt = '0;
      unique case (op_r) inside
        OP_ENQ: begin
          if (count_r == DEPTH_C) begin
            ovf_nxt = 1'b1;
          end else begin
            store_we  = 1'b1;
            live_we   = 1'b1;
            tail_nxt  = adv(tail_r);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DEQ, OP_SEARCH, OP_RM_FIRST, OP_RM_ALL: begin
          iss_left_nxt = count_r;
        end
        OP_PEEK: begin
          if (peek_in_range) begin
            iss_addr_nxt = peek_slot;
            iss_left_nxt = CW'(1);
          end
        end
        OP_POP: begin
          if (count_r != '0) begin
            tail_nxt     = ret(tail_r);
            count_nxt    = count_r - CW'(1);
            iss_addr_nxt = ret(tail_r);
            iss_left_nxt = CW'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      // Issue the next read until the scan stops or runs out
      issue      = (iss_left_r != '0) && !stop_r;
      rd_vld_nxt = issue;
      if (issue) begin
        iss_addr_nxt = adv(iss_addr_r);
        iss_left_nxt = iss_left_r - CW'(1);
      end
      // Evaluate the entry read last cycle
      if (rd_vld_r && !stop_r) begin
        unique case (op_r) inside
          OP_DEQ: begin
            head_nxt  = adv(head_r);
            count_nxt = count_r - CW'(1);
            if (rd_live_r) begin
              rv_nxt   = rd_data_r;
              hit_nxt  = 1'b1;
              stop_nxt = 1'b1;
            end
          end
          OP_SEARCH: begin
            if (match) begin
              hit_nxt  = 1'b1;
              stop_nxt = 1'b1;
            end
          end
          OP_RM_FIRST, OP_RM_ALL: begin
            if (match) begin
              live_we    = 1'b1;
              live_waddr = rd_addr_r;
              live_wdata = 1'b0;
              hit_nxt    = 1'b1;
              stop_nxt   = (op_r == OP_RM_FIRST);
            end
          end
          OP_PEEK, OP_POP: begin
            rv_nxt   = rd_data_r;
            hit_nxt  = 1'b1;
            dead_nxt = !rd_live_r;
            stop_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign sts.scan_done = stop_r || ((iss_left_r == '0) && !rd_vld_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Hold the result beat until taken; a new result reloads it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      iss_left_r  <= '0;
      rd_vld_r    <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      iss_left_r  <= iss_left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Widen the result and occupancy to port width
  assign rv_ext  = {{VALUE_PORT_W{1'b0}}, rv_r};
  assign occ_ext = {{OCC_W{1'b0}}, count_r};

  // Payload registers
  always_ff @(posedge clk) begin
    iss_addr_r <= iss_addr_nxt;
    rv_r       <= rv_nxt;
    hit_r      <= hit_nxt;
    dead_r     <= dead_nxt;
    ovf_r      <= ovf_nxt;
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      val_r <= in_item_value[VALUE_WIDTH-1:0];
      pos_r <= in_peek_position;
    end
    if (issue) begin
      rd_addr_r <= iss_addr_r;
    end
    if (cmd.emit) begin
      out_value_r <= rv_ext[VALUE_PORT_W-1:0];
      out_hit_r   <= hit_r;
      out_dead_r  <= dead_r;
      out_ovf_r   <= ovf_r;
      out_occ_r   <= occ_ext[OCC_W-1:0];
    end
  end

  // Value memory: write at tail, registered read
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[tail_r] <= val_r;
    end
    if (issue) begin
      rd_data_r <= store_mem[iss_addr_r];
    end
  end

  // Live-mark memory: set on enqueue, clear on remove, registered read
  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    if (issue) begin
      rd_live_r <= live_mem[iss_addr_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_hit          = out_hit_r;
  assign out_entry_dead   = out_dead_r;
  assign out_overflow     = out_ovf_r;
  assign out_occupancy    = out_occ_r;

endmodule

### sv/searchable_fifo_with_tombstones.sv
// Bounded FIFO of DEPTH values with lazy delete. Each beat on the input carries one operation
// (enqueue, dequeue, search, remove first, remove all, peek, pop) and yields exactly one result
// beat. One operation is in flight at a time; the next is taken the cycle after the result is
// loaded into the output register. Enqueue, an unused opcode, and a peek or pop that finds no
// entry pass from setup through scan to emit without a read of the entry memory. A peek or pop
// that finds an entry reads just that entry during the scan. Dequeue, search and the removes
// walk the entry memory, which has one read port, one entry per cycle from the head, stopping
// at the first live entry for dequeue and the first match for search and remove first.
module searchable_fifo_with_tombstones #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sfwt_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [sfwt_pkg::VALUE_PORT_W-1:0] in_item_value,
  input  logic [sfwt_pkg::POS_W-1:0]        in_peek_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sfwt_pkg::VALUE_PORT_W-1:0] out_result_value,
  output logic                              out_hit,
  output logic                              out_entry_dead,
  output logic                              out_overflow,
  output logic [sfwt_pkg::OCC_W-1:0]        out_occupancy
);
  import sfwt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence operations
  sfwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold entries, pointers and the result register
  sfwt_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_peek_position (in_peek_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_hit          (out_hit),
    .out_entry_dead   (out_entry_dead),
    .out_overflow     (out_overflow),
    .out_occupancy    (out_occupancy)
  );

endmodule

### dv/tb_searchable_fifo_with_tombstones.sv
`timescale 1ns / 100ps

module tb_searchable_fifo_with_tombstones;
  import sfwt_pkg::*;

  localparam int SLOTS        = 256;
  localparam int ITEM_TARGET  = 1150;
  localparam int QUIET_AFTER  = 1000;
  localparam int BIG_PHASE    = 300;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 300;

  // Opcode outside the defined set; the block treats it as a no-op
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic [VALUE_PORT_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } fifo_op_t;

  typedef struct packed {
    logic [VALUE_PORT_W-1:0] value;
    logic                    hit;
    logic                    dead;
    logic                    ovf;
    logic [OCC_W-1:0]        occ;
  } fifo_res_t;

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic [OPCODE_W-1:0]     in_opcode        = '0;
  logic [VALUE_PORT_W-1:0] in_item_value    = '0;
  logic [POS_W-1:0]        in_peek_position = '0;
  logic                    out_valid;
  logic                    out_ready        = 1'b0;
  logic [VALUE_PORT_W-1:0] out_result_value;
  logic                    out_hit;
  logic                    out_entry_dead;
  logic                    out_overflow;
  logic [OCC_W-1:0]        out_occupancy;

  // Shadow copy of the queue contents
  logic [VALUE_PORT_W-1:0] shadow_val [SLOTS];
  bit                      shadow_live [SLOTS];
  logic [7:0]              shadow_head  = '0;
  logic [7:0]              shadow_tail  = '0;
  int                      shadow_count = 0;

  fifo_op_t  pending_ops[$];
  fifo_res_t expected_results[$];
  fifo_op_t  on_wire;
  logic [VALUE_PORT_W-1:0] value_pool [8];

  int  n_queued    = 0;
  int  n_sent      = 0;
  int  n_taken     = 0;
  int  n_checked   = 0;
  int  n_errors    = 0;
  int  n_overflow  = 0;
  int  n_deq_miss  = 0;
  int  n_dead_seen = 0;
  int  n_peak      = 0;
  int  in_gap      = 0;
  int  out_gap     = 0;
  int  hold_left   = 0;
  int  hold_ticket = 0;
  int  hold_served = 0;
  bit  in_idle_en  = 1'b0;
  bit  out_idle_en = 1'b0;

  searchable_fifo_with_tombstones uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_peek_position (in_peek_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_hit          (out_hit),
    .out_entry_dead   (out_entry_dead),
    .out_overflow     (out_overflow),
    .out_occupancy    (out_occupancy)
  );

  always #10 clk = ~clk;

  // Apply one operation to the shadow queue and return the result it should produce
  function automatic fifo_res_t fifo_apply(input fifo_op_t op);
    fifo_res_t  r;
    logic [7:0] s;
    int         k;
    r = '0;
    case (op.opcode)
      OP_ENQ: begin
        if (shadow_count >= SLOTS) begin
          r.ovf = 1'b1;
          n_overflow++;
        end else begin
          shadow_val[shadow_tail]  = op.value;
          shadow_live[shadow_tail] = 1'b1;
          shadow_tail++;
          shadow_count++;
        end
      end
      OP_DEQ: begin
        // drop dead entries at the head until a live one comes out
        while (shadow_count > 0 && !r.hit) begin
          s = shadow_head;
          shadow_head++;
          shadow_count--;
          if (shadow_live[s]) begin
            r.value = shadow_val[s];
            r.hit   = 1'b1;
          end
        end
        if (!r.hit) n_deq_miss++;
      end
      OP_SEARCH: begin
        for (k = 0; k < shadow_count && !r.hit; k++) begin
          s = shadow_head + 8'(k);
          if (shadow_live[s] && shadow_val[s] == op.value) r.hit = 1'b1;
        end
      end
      OP_RM_FIRST, OP_RM_ALL: begin
        for (k = 0; k < shadow_count; k++) begin
          s = shadow_head + 8'(k);
          if (shadow_live[s] && shadow_val[s] == op.value &&
              !(op.opcode == OP_RM_FIRST && r.hit)) begin
            shadow_live[s] = 1'b0;
            r.hit          = 1'b1;
          end
        end
      end
      OP_PEEK: begin
        if (int'(op.pos) < shadow_count) begin
          s       = shadow_head + op.pos;
          r.value = shadow_val[s];
          r.hit   = 1'b1;
          r.dead  = !shadow_live[s];
        end
      end
      OP_POP: begin
        if (shadow_count > 0) begin
          shadow_tail--;
          shadow_count--;
          r.value = shadow_val[shadow_tail];
          r.hit   = 1'b1;
          r.dead  = !shadow_live[shadow_tail];
        end
      end
      default: ;
    endcase
    if (r.dead) n_dead_seen++;
    if (shadow_count > n_peak) n_peak = shadow_count;
    r.occ = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [VALUE_PORT_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly values from the phase pool so that searches and removes find matches
  function automatic logic [VALUE_PORT_W-1:0] pick_value();
    if ($urandom_range(0, 6) != 0) return value_pool[$urandom_range(0, 7)];
    return rand_word();
  endfunction

  task automatic push_op(input logic [OPCODE_W-1:0] opcode,
                         input logic [VALUE_PORT_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    fifo_op_t b;
    b.opcode = opcode;
    b.value  = value;
    b.pos    = pos;
    pending_ops.push_back(b);
    n_queued++;
  endtask

  // Mixed traffic steered toward a target fill level
  task automatic gen_mixed(input int n, input int goal);
    int est;
    int r;
    int i;
    est = shadow_count;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ((est < goal) ? 55 : 20)) begin
        push_op(OP_ENQ, pick_value(), POS_W'($urandom()));
        if (est < SLOTS) est++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 22) begin
          push_op(OP_DEQ, rand_word(), POS_W'($urandom()));
          if (est > 0) est--;
        end else if (r < 40) begin
          push_op(OP_SEARCH, pick_value(), POS_W'($urandom()));
        end else if (r < 54) begin
          push_op(OP_RM_FIRST, pick_value(), POS_W'($urandom()));
        end else if (r < 64) begin
          push_op(OP_RM_ALL, pick_value(), POS_W'($urandom()));
        end else if (r < 82) begin
          push_op(OP_PEEK, rand_word(), (est > 0 && $urandom_range(0, 3) != 0) ?
                  POS_W'($urandom_range(0, est - 1)) : POS_W'($urandom()));
        end else if (r < 97) begin
          push_op(OP_POP, rand_word(), POS_W'($urandom()));
          if (est > 0) est--;
        end else begin
          push_op(OP_UNUSED, rand_word(), POS_W'($urandom()));
        end
      end
    end
  endtask

  // Fill to the brim, overflow, then probe and trim the full queue
  task automatic gen_fill();
    int i;
    for (i = shadow_count; i < SLOTS + 3; i++)
      push_op(OP_ENQ, pick_value(), POS_W'($urandom()));
    push_op(OP_PEEK, rand_word(), 8'hFF);
    push_op(OP_PEEK, rand_word(), 8'h00);
    push_op(OP_PEEK, rand_word(), POS_W'($urandom()));
    push_op(OP_SEARCH, pick_value(), 8'h00);
    push_op(OP_SEARCH, rand_word(), 8'h00);
    push_op(OP_RM_FIRST, pick_value(), 8'h00);
    push_op(OP_RM_ALL, pick_value(), 8'h00);
    push_op(OP_PEEK, rand_word(), 8'hFF);
    push_op(OP_ENQ, pick_value(), 8'h00);
    push_op(OP_POP, rand_word(), 8'h00);
    push_op(OP_POP, rand_word(), 8'h00);
    push_op(OP_ENQ, pick_value(), 8'h00);
    for (i = 0; i < 3; i++) push_op(OP_DEQ, rand_word(), 8'h00);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || n_sent != n_taken || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: hold each beat until taken, predict on acceptance, insert idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(fifo_apply(on_wire));
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          on_wire = pending_ops.pop_front();
          n_sent++;
          in_opcode        <= on_wire.opcode;
          in_item_value    <= on_wire.value;
          in_peek_position <= on_wire.pos;
          in_valid         <= 1'b1;
          if (in_idle_en && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction, stall at random
  always @(posedge clk) begin
    fifo_res_t got;
    fifo_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{value: out_result_value, hit: out_hit, dead: out_entry_dead,
                ovf: out_overflow, occ: out_occupancy};
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result beat: value=%h hit=%b dead=%b ovf=%b occ=%0d",
                     got.value, got.hit, got.dead, got.ovf, got.occ);
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value || got.hit !== want.hit || got.dead !== want.dead ||
              got.ovf !== want.ovf || got.occ !== want.occ) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result %0d mismatch: expected value=%h hit=%b dead=%b ovf=%b occ=%0d",
                       n_checked, want.value, want.hit, want.dead, want.ovf, want.occ);
              $display("  got value=%h hit=%b dead=%b ovf=%b occ=%0d",
                       got.value, got.hit, got.dead, got.ovf, got.occ);
            end
          end
        end
        n_checked++;
      end
      if (hold_served != hold_ticket) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int phase_no;
    int i;
    bit big_ok;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue: every read and remove misses, unused opcode does nothing
    push_op(OP_DEQ, rand_word(), 8'h00);
    push_op(OP_POP, '1, 8'hFF);
    push_op(OP_PEEK, '0, 8'h00);
    push_op(OP_SEARCH, '0, 8'h00);
    push_op(OP_RM_FIRST, '1, 8'h00);
    push_op(OP_RM_ALL, '0, 8'h00);
    push_op(OP_UNUSED, '1, 8'hFF);
    // extreme values, one duplicated
    push_op(OP_ENQ, '0, 8'hFF);
    push_op(OP_ENQ, '1, 8'h00);
    push_op(OP_ENQ, 64'h5555_5555_5555_5555, 8'h00);
    push_op(OP_ENQ, '1, 8'h00);
    push_op(OP_ENQ, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00);
    push_op(OP_SEARCH, '1, 8'h00);
    push_op(OP_SEARCH, 64'h1234_5678_9ABC_DEF0, 8'h00);
    // kill the first all-ones entry, peek it, peek past the end
    push_op(OP_RM_FIRST, '1, 8'h00);
    push_op(OP_PEEK, '0, 8'h01);
    push_op(OP_PEEK, '0, 8'hFF);
    push_op(OP_RM_ALL, '1, 8'h00);
    // pop a live then a dead entry, dequeue across a dead one
    push_op(OP_POP, '0, 8'h00);
    push_op(OP_POP, '0, 8'h00);
    push_op(OP_DEQ, '0, 8'h00);
    push_op(OP_DEQ, '0, 8'h00);
    // dequeue with only dead entries left
    push_op(OP_ENQ, 64'h0123_4567_89AB_CDEF, 8'h00);
    push_op(OP_RM_FIRST, 64'h0123_4567_89AB_CDEF, 8'h00);
    push_op(OP_DEQ, '0, 8'h00);
    wait_idle();

    phase_no = 0;
    while (n_queued < ITEM_TARGET) begin
      if (n_queued >= QUIET_AFTER) begin
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end else begin
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
      end
      for (i = 0; i < 8; i++) value_pool[i] = rand_word();
      if ($urandom_range(0, 2) == 0) value_pool[0] = '0;
      if ($urandom_range(0, 2) == 0) value_pool[1] = '1;
      // keep the long fill and drain phases clear of the end of the run
      big_ok = (n_queued + BIG_PHASE <= ITEM_TARGET);

      if (phase_no == 2) begin
        // stall the receiver long enough to back up the input
        hold_ticket++;
        gen_mixed(40, SLOTS);
      end else if ((phase_no == 5 || phase_no == 13) && big_ok) begin
        gen_fill();
      end else if (phase_no % 4 == 3 && big_ok) begin
        for (i = 0; i < shadow_count + 2; i++) push_op(OP_DEQ, rand_word(), POS_W'($urandom()));
      end else begin
        gen_mixed(40, $urandom_range(0, SLOTS));
      end
      wait_idle();
      phase_no++;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("ran %0d operations, checked %0d results, peak occupancy %0d of %0d",
             n_taken, n_checked, n_peak, SLOTS);
    $display("%0d dropped enqueues, %0d empty dequeues, %0d dead entries read, %0d errors",
             n_overflow, n_deq_miss, n_dead_seen, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_searchable_fifo_with_tombstones: clean");
    end else begin
      $display("tb_searchable_fifo_with_tombstones: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("tb_searchable_fifo_with_tombstones: errors");
    $finish;
  end

endmodule

### searchable_fifo_with_tombstones.f
sv/sfwt_pkg.sv
sv/sfwt_ctrl.sv
sv/sfwt_dp.sv
sv/searchable_fifo_with_tombstones.sv
dv/tb_searchable_fifo_with_tombstones.sv
